[rtl/bpfa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpfa_pkg: shared types and constants of the bitmap page-frame allocator
// Item layouts, opcode and status codes, register indexes, bit helpers.
// ----------------------------------------------------------------------------
package bpfa_pkg;

	localparam int REG_W           = 11;
	localparam int MAX_BUCKETS_DEF = 1024;
	localparam int BUCKET_W        = 8;
	localparam int FRAME_SHIFT     = 12;
	localparam int BUCKET_SHIFT    = 15;
	localparam int ADDR_BKT_W      = 17;
	localparam int CFG_IDX_W       = 1;

	localparam logic [31:0]         UPPER_BASE  = 32'h0010_0000;
	localparam logic [BUCKET_W-1:0] BUCKET_FULL = 8'hFF;

	typedef enum logic [1:0] {
		OP_INIT  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE  = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_FRAME  = 3'd1,
		ST_UNALIGNED = 3'd2,
		ST_LOW       = 3'd3,
		ST_BEYOND    = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BUCKET_COUNT = 1'd0,
		CFG_RESERVED     = 1'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] free_address;
	} req_t;

	typedef struct packed {
		logic [31:0] frame_address;
		logic [2:0]  status;
	} rsp_t;

	// outcome of the address checks of a free
	typedef struct packed {
		logic [2:0]            status;
		logic [ADDR_BKT_W-1:0] bucket;
		logic [2:0]            bit_idx;
	} free_chk_t;

	// position of the lowest clear bit of a bucket
	function automatic logic [2:0] lowest_zero(input logic [BUCKET_W-1:0] bits);
		logic [2:0] pos;
		pos = 3'd0;
		for (int k = BUCKET_W - 1; k >= 0; k--) begin
			if (!bits[k])
				pos = 3'(k);
		end
		return pos;
	endfunction

endpackage
`default_nettype wire

[rtl/bitmap_page_frame_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator: first-fit page-frame allocator over a bitmap
// Buckets of eight frame bits in one RAM; read, modify, write back.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_t  (opcode, free_address)
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_t  (frame_address, status)
//  cfg     | in        | cfg_we               | cfg_index, cfg_data
//
//  Alloc reads and checks buckets from the first-fit hint onward, with
//  registered RAM reads; Free reads, clears and writes back; Init writes n.
//  After reset a clearing pass writes all MAX_BUCKETS buckets to zero, one a
//  cycle, while req_stall is held high. One item is in work at a time; a
//  finished result waits in the output register while the next item enters.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator
	import bpfa_pkg::*;
#(
	parameter int MAX_BUCKETS = MAX_BUCKETS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_stall,
	input  wire req_t                 req,
	output logic                      rsp_valid,
	input  wire logic                 rsp_stall,
	output rsp_t                      rsp,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [REG_W-1:0]     cfg_data
);

	localparam int CNT_W  = $clog2(MAX_BUCKETS + 1);
	localparam int ADDR_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int CMP_W  = (CNT_W > REG_W) ? CNT_W : REG_W;

	typedef enum logic [7:0] {
		S_CLEAR  = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_INIT   = 8'b0000_0100,
		S_AREAD  = 8'b0000_1000,
		S_ACHECK = 8'b0001_0000,
		S_FREAD  = 8'b0010_0000,
		S_FWRITE = 8'b0100_0000,
		S_RESP   = 8'b1000_0000
	} state_t;

	state_t             state_q;
	logic [REG_W-1:0]   bucket_count_q;
	logic [REG_W-1:0]   reserved_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   hint_q;
	logic [2:0]         bit_q;
	rsp_t               res_q;
	rsp_t               rsp_q;
	logic               rsp_valid_q;

	logic [CMP_W-1:0]    cnt_ext;
	logic [CMP_W-1:0]    rsv_ext;
	logic [CNT_W-1:0]    n_use;
	logic [CNT_W-1:0]    r_use;
	logic [CNT_W-1:0]    idx_nxt;
	logic                accept;
	free_chk_t           chk;

	logic                ram_we;
	logic                ram_re;
	logic [ADDR_W-1:0]   ram_addr;
	logic [BUCKET_W-1:0] ram_wdata;
	logic [BUCKET_W-1:0] ram_rdata;
	logic [2:0]          zero_bit;
	logic [BUCKET_W-1:0] set_bits;

	// clamp the counts to what the map holds
	assign cnt_ext = CMP_W'(bucket_count_q);
	assign rsv_ext = CMP_W'(reserved_q);
	assign n_use   = (cnt_ext > CMP_W'(MAX_BUCKETS)) ? CNT_W'(MAX_BUCKETS) : CNT_W'(cnt_ext);
	assign r_use   = (rsv_ext > CMP_W'(n_use)) ? n_use : CNT_W'(rsv_ext);

	assign idx_nxt   = idx_q + CNT_W'(1);
	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign zero_bit = lowest_zero(ram_rdata);
	assign set_bits = ram_rdata | (BUCKET_W'(1) << zero_bit);
	assign ram_addr = idx_q[ADDR_W-1:0];

	bpfa_free_chk #(
		.CNT_W(CNT_W)
	) u_free_chk (
		.free_address(req.free_address),
		.n_use       (n_use),
		.chk         (chk)
	);

	bpfa_ram #(
		.WIDTH(BUCKET_W),
		.DEPTH(MAX_BUCKETS)
	) u_bitmap (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_addr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_addr),
		.rdata(ram_rdata)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = (idx_q < r_use) ? BUCKET_FULL : '0;
			end
			S_AREAD, S_FREAD: begin
				ram_re = 1'b1;
			end
			S_ACHECK: begin
				ram_we    = (ram_rdata != BUCKET_FULL);
				ram_wdata = set_bits;
			end
			S_FWRITE: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata & ~(BUCKET_W'(1) << bit_q);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= REG_W'(MAX_BUCKETS_DEF);
			reserved_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BUCKET_COUNT: bucket_count_q <= cfg_data;
				CFG_RESERVED:     reserved_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			idx_q   <= '0;
			hint_q  <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					idx_q <= idx_nxt;
					if (idx_q == CNT_W'(MAX_BUCKETS - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						case (req.opcode)
							OP_INIT: begin
								idx_q <= '0;
								if (n_use == '0)
									state_q <= S_RESP;
								else
									state_q <= S_INIT;
							end
							OP_ALLOC: begin
								idx_q <= hint_q;
								if (hint_q >= n_use)
									state_q <= S_RESP;
								else
									state_q <= S_AREAD;
							end
							OP_FREE: begin
								idx_q <= CNT_W'(chk.bucket);
								if (chk.status != ST_OK)
									state_q <= S_RESP;
								else
									state_q <= S_FREAD;
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_INIT: begin
					idx_q <= idx_nxt;
					if (idx_nxt == n_use) begin
						hint_q  <= r_use;
						state_q <= S_RESP;
					end
				end
				S_AREAD: begin
					state_q <= S_ACHECK;
				end
				S_ACHECK: begin
					if (ram_rdata == BUCKET_FULL) begin
						// every bucket up to the end is full
						if (idx_nxt >= n_use) begin
							hint_q  <= n_use;
							state_q <= S_RESP;
						end else begin
							idx_q   <= idx_nxt;
							state_q <= S_AREAD;
						end
					end else begin
						hint_q  <= (set_bits == BUCKET_FULL) ? idx_nxt : idx_q;
						state_q <= S_RESP;
					end
				end
				S_FREAD: begin
					state_q <= S_FWRITE;
				end
				S_FWRITE: begin
					if (idx_q < hint_q)
						hint_q <= idx_q;
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!rsp_valid_q || !rsp_stall)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result payload, built up while the item is in work
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			res_q.frame_address <= '0;
			bit_q               <= chk.bit_idx;
			if (req.opcode == OP_ALLOC && hint_q >= n_use)
				res_q.status <= ST_NO_FRAME;
			else if (req.opcode == OP_FREE)
				res_q.status <= chk.status;
			else
				res_q.status <= ST_OK;
		end else if (state_q == S_ACHECK) begin
			if (ram_rdata != BUCKET_FULL)
				res_q.frame_address <= (32'(idx_q) << BUCKET_SHIFT)
					+ (32'(zero_bit) << FRAME_SHIFT) + UPPER_BASE;
			else if (idx_nxt >= n_use)
				res_q.status <= ST_NO_FRAME;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (state_q == S_RESP && (!rsp_valid_q || !rsp_stall))
			rsp_valid_q <= 1'b1;
		else if (!rsp_stall)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && (!rsp_valid_q || !rsp_stall))
			rsp_q <= res_q;
	end

`ifndef ASSERT_OFF
	a_rsp_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == S_RESP))
		else $error("result shown without a finished item");

	a_err_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.frame_address == '0)
		else $error("failed item carries a frame address");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !ram_we)
		else $error("bitmap written while idle");

	a_hint_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hint_q <= CNT_W'(MAX_BUCKETS))
		else $error("first-fit hint beyond the map");
`endif

endmodule
`default_nettype wire

[rtl/bpfa_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpfa_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bpfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[rtl/bpfa_free_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpfa_free_chk: address checks of a free
// Alignment, lower bound and map bound, in that order; splits out bucket/bit.
// ----------------------------------------------------------------------------
module bpfa_free_chk
	import bpfa_pkg::*;
#(
	parameter int CNT_W = 11
) (
	input  wire logic [31:0]    free_address,
	input  wire logic [CNT_W-1:0] n_use,
	output free_chk_t           chk
);

	logic [31:0] offset;

	assign offset = free_address - UPPER_BASE;

	always_comb begin
		chk.bucket  = offset[31:BUCKET_SHIFT];
		chk.bit_idx = offset[BUCKET_SHIFT-1:FRAME_SHIFT];
		if (free_address[FRAME_SHIFT-1:0] != '0)
			chk.status = ST_UNALIGNED;
		else if (free_address < UPPER_BASE)
			chk.status = ST_LOW;
		else if (32'(chk.bucket) >= 32'(n_use))
			chk.status = ST_BEYOND;
		else
			chk.status = ST_OK;
	end

endmodule
`default_nettype wire
